// ===== sv/rhc_pkg.sv =====
// Shared definitions for the RGB to HSV converter.
// Holds the default component width and the control flags carried down the cell row.
// No dependencies.
package rhc_pkg;

    // Default width of one color component and of each result field.
    localparam int RHC_COMPONENT_BITS = 16;

    // Control flags that travel with each pixel from the front stage to the output.
    typedef struct packed {
        logic valid;     // a pixel occupies this stage
        logic hue_zero;  // grey pixel: max equals min, hue forced to zero
        logic sat_zero;  // black pixel: max is zero, saturation forced to zero
    } t_rhc_flags;

endpackage

// ===== sv/rhc_prep.sv =====
// Front stage of the RGB to HSV converter: max, min, chroma and hue numerator.
// Depends on rhc_pkg for the flag struct and the default width.
module rhc_prep
    import rhc_pkg::*;
#(
    parameter int COMPONENT_BITS = RHC_COMPONENT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [COMPONENT_BITS-1:0]   i_red,
    input  logic [COMPONENT_BITS-1:0]   i_green,
    input  logic [COMPONENT_BITS-1:0]   i_blue,
    output t_rhc_flags                  o_flags,
    output logic [COMPONENT_BITS-1:0]   o_max,
    output logic [COMPONENT_BITS-1:0]   o_chroma,
    output logic [COMPONENT_BITS+2:0]   o_turn
);

    localparam int B  = COMPONENT_BITS;
    localparam int NW = B + 3;

    logic [B-1:0]  mx;
    logic [B-1:0]  mn;
    logic [B-1:0]  chroma;
    logic [NW-1:0] chroma_x;
    logic [NW-1:0] offset;
    logic [NW-1:0] plus_term;
    logic [NW-1:0] minus_term;

    t_rhc_flags    r_flags;
    t_rhc_flags    n_flags;
    logic [B-1:0]  r_max;
    logic [B-1:0]  r_chroma;
    logic [NW-1:0] r_turn;
    logic [NW-1:0] n_turn;

    always_comb begin
        mx = i_red;
        if (i_green > mx) begin
            mx = i_green;
        end
        if (i_blue > mx) begin
            mx = i_blue;
        end
        mn = i_red;
        if (i_green < mn) begin
            mn = i_green;
        end
        if (i_blue < mn) begin
            mn = i_blue;
        end
        chroma   = mx - mn;
        chroma_x = {3'b000, chroma};

        // The turn numerator lies in [0, 6*chroma), so arithmetic modulo the
        // register width gives the exact value even with a negative difference.
        if (i_red == mx) begin
            offset     = (i_green >= i_blue) ? '0
                                             : (chroma_x << 2) + (chroma_x << 1);
            plus_term  = {3'b000, i_green};
            minus_term = {3'b000, i_blue};
        end else if (i_green == mx) begin
            offset     = chroma_x << 1;
            plus_term  = {3'b000, i_blue};
            minus_term = {3'b000, i_red};
        end else begin
            offset     = chroma_x << 2;
            plus_term  = {3'b000, i_red};
            minus_term = {3'b000, i_green};
        end
        n_turn = offset + plus_term - minus_term;

        n_flags.valid    = i_load;
        n_flags.hue_zero = (chroma == '0);
        n_flags.sat_zero = (mx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_max    <= mx;
        r_chroma <= chroma;
        r_turn   <= n_turn;
    end

    assign o_flags  = r_flags;
    assign o_max    = r_max;
    assign o_chroma = r_chroma;
    assign o_turn   = r_turn;

endmodule

// ===== sv/rhc_cell.sv =====
// One cell of the divider row: a restoring division step for hue and for saturation.
// Depends on rhc_pkg for the flag struct and the default width.
module rhc_cell
    import rhc_pkg::*;
#(
    parameter int COMPONENT_BITS = RHC_COMPONENT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_rhc_flags                  i_flags,
    input  logic [COMPONENT_BITS-1:0]   i_max,
    input  logic [COMPONENT_BITS+2:0]   i_hue_rem,
    input  logic [COMPONENT_BITS:0]     i_hue_low,
    input  logic [COMPONENT_BITS+2:0]   i_hue_div,
    input  logic [COMPONENT_BITS:0]     i_hue_quo,
    input  logic [COMPONENT_BITS+2:0]   i_sat_rem,
    input  logic [COMPONENT_BITS:0]     i_sat_low,
    input  logic [COMPONENT_BITS+2:0]   i_sat_div,
    input  logic [COMPONENT_BITS:0]     i_sat_quo,
    output t_rhc_flags                  o_flags,
    output logic [COMPONENT_BITS-1:0]   o_max,
    output logic [COMPONENT_BITS+2:0]   o_hue_rem,
    output logic [COMPONENT_BITS:0]     o_hue_low,
    output logic [COMPONENT_BITS+2:0]   o_hue_div,
    output logic [COMPONENT_BITS:0]     o_hue_quo,
    output logic [COMPONENT_BITS+2:0]   o_sat_rem,
    output logic [COMPONENT_BITS:0]     o_sat_low,
    output logic [COMPONENT_BITS+2:0]   o_sat_div,
    output logic [COMPONENT_BITS:0]     o_sat_quo
);

    localparam int B  = COMPONENT_BITS;
    localparam int RW = B + 3;
    localparam int LW = B + 1;

    logic [RW:0]   hue_trial;
    logic [RW:0]   sat_trial;
    logic          hue_fit;
    logic          sat_fit;

    t_rhc_flags    r_flags;
    logic [B-1:0]  r_max;
    logic [RW-1:0] r_hue_rem;
    logic [RW-1:0] n_hue_rem;
    logic [LW-1:0] r_hue_low;
    logic [RW-1:0] r_hue_div;
    logic [LW-1:0] r_hue_quo;
    logic [RW-1:0] r_sat_rem;
    logic [RW-1:0] n_sat_rem;
    logic [LW-1:0] r_sat_low;
    logic [RW-1:0] r_sat_div;
    logic [LW-1:0] r_sat_quo;

    // Bring down the next dividend bit and subtract the divisor where it fits.
    always_comb begin
        hue_trial = {i_hue_rem, i_hue_low[LW-1]};
        hue_fit   = (hue_trial >= {1'b0, i_hue_div});
        n_hue_rem = hue_fit ? RW'(hue_trial - {1'b0, i_hue_div}) : hue_trial[RW-1:0];

        sat_trial = {i_sat_rem, i_sat_low[LW-1]};
        sat_fit   = (sat_trial >= {1'b0, i_sat_div});
        n_sat_rem = sat_fit ? RW'(sat_trial - {1'b0, i_sat_div}) : sat_trial[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= i_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_max     <= i_max;
        r_hue_rem <= n_hue_rem;
        r_hue_low <= {i_hue_low[LW-2:0], 1'b0};
        r_hue_div <= i_hue_div;
        r_hue_quo <= {i_hue_quo[LW-2:0], hue_fit};
        r_sat_rem <= n_sat_rem;
        r_sat_low <= {i_sat_low[LW-2:0], 1'b0};
        r_sat_div <= i_sat_div;
        r_sat_quo <= {i_sat_quo[LW-2:0], sat_fit};
    end

    assign o_flags   = r_flags;
    assign o_max     = r_max;
    assign o_hue_rem = r_hue_rem;
    assign o_hue_low = r_hue_low;
    assign o_hue_div = r_hue_div;
    assign o_hue_quo = r_hue_quo;
    assign o_sat_rem = r_sat_rem;
    assign o_sat_low = r_sat_low;
    assign o_sat_div = r_sat_div;
    assign o_sat_quo = r_sat_quo;

endmodule

// ===== sv/rgb_to_hsv_converter_core.sv =====
// Top level of the RGB to HSV converter: front stage plus a row of divider cells.
// Depends on rhc_pkg, rhc_prep and rhc_cell.
//
// Channel   Direction  Handshake               Payload
// pixel     in         start high, busy low    i_red, i_green, i_blue
// result    out        o_valid for one cycle   o_hue, o_saturation, o_brightness
//
// A pixel is taken in every cycle; busy is never raised, so start may be held high.
// Each pixel passes through the front stage register and then through each of the
// COMPONENT_BITS + 1 divider cell registers before it leaves.
// The cell row computes one quotient bit per cell.
// Reset clears only the flag registers; the data registers flush as pixels move.
// The receiver cannot stall, and no state carries from one pixel to the next.
module rgb_to_hsv_converter_core
    import rhc_pkg::*;
#(
    parameter int COMPONENT_BITS = RHC_COMPONENT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [COMPONENT_BITS-1:0]   i_red,
    input  logic [COMPONENT_BITS-1:0]   i_green,
    input  logic [COMPONENT_BITS-1:0]   i_blue,
    output logic                        o_valid,
    output logic [COMPONENT_BITS-1:0]   o_hue,
    output logic [COMPONENT_BITS-1:0]   o_saturation,
    output logic [COMPONENT_BITS-1:0]   o_brightness
);

    localparam int B       = COMPONENT_BITS;
    localparam int RW      = B + 3;
    localparam int LW      = B + 1;
    localparam int NCELL   = B + 1;
    localparam int LATENCY = B + 2;

    // Front stage outputs.
    t_rhc_flags      prep_flags;
    logic [B-1:0]    prep_max;
    logic [B-1:0]    prep_chroma;
    logic [B+2:0]    prep_turn;

    // Dividends and divisors formed from the front stage registers.
    logic [B+1:0]    chroma3;
    logic [2*B+2:0]  hue_num;
    logic [RW-1:0]   hue_den;
    logic [2*B+1:0]  sat_num;
    logic [RW-1:0]   sat_den;

    // Links between neighboring cells; index 0 feeds the first cell.
    t_rhc_flags      link_flags [0:NCELL];
    logic [B-1:0]    link_max   [0:NCELL];
    logic [RW-1:0]   link_hrem  [0:NCELL];
    logic [LW-1:0]   link_hlow  [0:NCELL];
    logic [RW-1:0]   link_hdiv  [0:NCELL];
    logic [LW-1:0]   link_hquo  [0:NCELL];
    logic [RW-1:0]   link_srem  [0:NCELL];
    logic [LW-1:0]   link_slow  [0:NCELL];
    logic [RW-1:0]   link_sdiv  [0:NCELL];
    logic [LW-1:0]   link_squo  [0:NCELL];

    // The block is fully pipelined and takes a pixel on every clock.
    assign busy = 1'b0;

    rhc_prep #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (start),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .o_flags  (prep_flags),
        .o_max    (prep_max),
        .o_chroma (prep_chroma),
        .o_turn   (prep_turn)
    );

    // Hue is round(n / (6*d) * 2^B), computed as floor((n * 2^B + 3d) / (6d)).
    // Saturation is floor((2*d*(2^B - 1) + max) / (2*max)).
    // Both quotients fit in B + 1 bits, so the upper part of each dividend
    // starts out below its divisor and the row needs B + 1 steps.
    always_comb begin
        chroma3 = {2'b00, prep_chroma} + {1'b0, prep_chroma, 1'b0};
        hue_num = {prep_turn, {B{1'b0}}} + {{(B+1){1'b0}}, chroma3};
        hue_den = {1'b0, prep_chroma, 2'b00} + {2'b00, prep_chroma, 1'b0};
        sat_num = {1'b0, prep_chroma, {(B+1){1'b0}}}
                - {{(B+1){1'b0}}, prep_chroma, 1'b0}
                + {{(B+2){1'b0}}, prep_max};
        sat_den = {2'b00, prep_max, 1'b0};
    end

    assign link_flags[0] = prep_flags;
    assign link_max[0]   = prep_max;
    assign link_hrem[0]  = {1'b0, hue_num[2*B+2:B+1]};
    assign link_hlow[0]  = hue_num[B:0];
    assign link_hdiv[0]  = hue_den;
    assign link_hquo[0]  = '0;
    assign link_srem[0]  = {2'b00, sat_num[2*B+1:B+1]};
    assign link_slow[0]  = sat_num[B:0];
    assign link_sdiv[0]  = sat_den;
    assign link_squo[0]  = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rhc_cell #(
            .COMPONENT_BITS (COMPONENT_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_flags   (link_flags[k]),
            .i_max     (link_max[k]),
            .i_hue_rem (link_hrem[k]),
            .i_hue_low (link_hlow[k]),
            .i_hue_div (link_hdiv[k]),
            .i_hue_quo (link_hquo[k]),
            .i_sat_rem (link_srem[k]),
            .i_sat_low (link_slow[k]),
            .i_sat_div (link_sdiv[k]),
            .i_sat_quo (link_squo[k]),
            .o_flags   (link_flags[k+1]),
            .o_max     (link_max[k+1]),
            .o_hue_rem (link_hrem[k+1]),
            .o_hue_low (link_hlow[k+1]),
            .o_hue_div (link_hdiv[k+1]),
            .o_hue_quo (link_hquo[k+1]),
            .o_sat_rem (link_srem[k+1]),
            .o_sat_low (link_slow[k+1]),
            .o_sat_div (link_sdiv[k+1]),
            .o_sat_quo (link_squo[k+1])
        );
    end

    // A hue that rounds up to a full turn drops its top bit and wraps to zero.
    // Grey and black pixels had a zero divisor, so their quotients are replaced.
    assign o_valid      = link_flags[NCELL].valid;
    assign o_brightness = link_max[NCELL];
    assign o_hue        = link_flags[NCELL].hue_zero ? '0 : link_hquo[NCELL][B-1:0];
    assign o_saturation = link_flags[NCELL].sat_zero ? '0 : link_squo[NCELL][B-1:0];

`ifndef SYNTH
    a_valid_follows_start : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY)
    ) else $error("result strobe without a pixel transfer at the expected cycle");

    a_black_is_zero : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_brightness == '0)) |-> ((o_saturation == '0) && (o_hue == '0))
    ) else $error("black pixel with nonzero hue or saturation");

    a_hue_needs_chroma : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hue != '0)) |-> (o_saturation != '0)
    ) else $error("nonzero hue on a pixel with zero saturation");
`endif

endmodule
